@@ rtl/rps_pkg.sv @@
// Package: constants, types and helpers for the ply stiffness rotation block.
`timescale 1ns / 1ps
package rps_pkg;

   localparam int FracBitsDefault    = 16;
   localparam int CordicStepsDefault = 16;
   localparam int AtanCount          = 24;
   localparam int AngW               = 32;
   localparam int CoefW              = 32;
   localparam int OutW               = 40;
   localparam logic signed [33:0] CordicKinv = 34'sd652032874;

   localparam logic [2:0] RowLast = 3'd5;

   typedef logic signed [CoefW-1:0] coef_type;

   // Ten packed coefficients, handed from front to back.
   typedef struct packed {
      coef_type d00, d11, d22, d33, o01, o12, o23, o02, o13, o03;
   } coefs_type;

   function automatic logic signed [31:0] atan_val(input logic [4:0] i);
      logic signed [31:0] r;
      begin
         r = 32'sd0;
         case (i)
            5'd0:  r = 32'sh20000000;
            5'd1:  r = 32'sh12E4051E;
            5'd2:  r = 32'sh09FB385B;
            5'd3:  r = 32'sh051111D4;
            5'd4:  r = 32'sh028B0D43;
            5'd5:  r = 32'sh0145D7E1;
            5'd6:  r = 32'sh00A2F61E;
            5'd7:  r = 32'sh00517C55;
            5'd8:  r = 32'sh0028BE53;
            5'd9:  r = 32'sh00145F2F;
            5'd10: r = 32'sh000A2F98;
            5'd11: r = 32'sh000517CC;
            5'd12: r = 32'sh00028BE6;
            5'd13: r = 32'sh000145F3;
            5'd14: r = 32'sh0000A2FA;
            5'd15: r = 32'sh0000517D;
            5'd16: r = 32'sh000028BE;
            5'd17: r = 32'sh0000145F;
            5'd18: r = 32'sh00000A30;
            5'd19: r = 32'sh00000518;
            5'd20: r = 32'sh0000028C;
            5'd21: r = 32'sh00000146;
            5'd22: r = 32'sh000000A3;
            5'd23: r = 32'sh00000051;
            default: r = 32'sd0;
         endcase
         return r;
      end
   endfunction

endpackage

@@ rtl/rps_cordic.sv @@
// Front part: takes items, runs the iterative CORDIC and builds sine and cosine.
`timescale 1ns / 1ps
module rps_cordic #(
   parameter int FRAC_BITS    = rps_pkg::FracBitsDefault,
   parameter int CORDIC_STEPS = rps_pkg::CordicStepsDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic signed [15:0]      req_angle,
   input  rps_pkg::coefs_type      req_coefs,
   input  logic                    q_full,
   output logic                    q_push,
   output logic signed [FRAC_BITS+1:0] q_sin,
   output logic signed [FRAC_BITS+1:0] q_cos,
   output rps_pkg::coefs_type      q_coefs
);
   localparam int Steps = (CORDIC_STEPS < rps_pkg::AtanCount) ? CORDIC_STEPS
                                                              : rps_pkg::AtanCount;
   localparam int Sh = 30 - FRAC_BITS;

   logic               run_ff, run_in, done_ff, done_in, flip_ff, flip_in;
   logic [4:0]         i_ff, i_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [32:0] z_ff, z_in;
   rps_pkg::coefs_type coefs_ff, coefs_in;

   logic [31:0] zu;
   logic        fl;
   logic signed [33:0] xf, yf, cr, sr;

   assign busy = run_ff | done_ff;

   always_comb begin
      zu = {req_angle, 16'd0};
      fl = (zu[31:30] == 2'd1) || (zu[31:30] == 2'd2);
      run_in = run_ff; done_in = done_ff; flip_in = flip_ff; i_in = i_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff; coefs_in = coefs_ff;
      if (start && !busy) begin
         run_in = 1'b1; flip_in = fl; i_in = 5'd0;
         x_in = rps_pkg::CordicKinv; y_in = 34'sd0;
         z_in = {{1{zu[31] ^ fl}}, zu[31] ^ fl, zu[30:0]};
         coefs_in = req_coefs;
      end else if (run_ff) begin
         if (!z_ff[32]) begin
            x_in = x_ff - (y_ff >>> i_ff);
            y_in = y_ff + (x_ff >>> i_ff);
            z_in = z_ff - 33'(rps_pkg::atan_val(i_ff));
         end else begin
            x_in = x_ff + (y_ff >>> i_ff);
            y_in = y_ff - (x_ff >>> i_ff);
            z_in = z_ff + 33'(rps_pkg::atan_val(i_ff));
         end
         i_in = i_ff + 5'd1;
         if (i_ff == 5'(Steps - 1)) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end else if (done_ff && !q_full) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in;
      end
      flip_ff <= flip_in; i_ff <= i_in; x_ff <= x_in; y_ff <= y_in;
      z_ff <= z_in; coefs_ff <= coefs_in;
   end

   always_comb begin
      xf = flip_ff ? -x_ff : x_ff;
      yf = flip_ff ? -y_ff : y_ff;
      cr = (xf + (34'sd1 <<< (Sh - 1))) >>> Sh;
      sr = (yf + (34'sd1 <<< (Sh - 1))) >>> Sh;
   end

   assign q_push  = done_ff && !q_full;
   assign q_cos   = cr[FRAC_BITS+1:0];
   assign q_sin   = sr[FRAC_BITS+1:0];
   assign q_coefs = coefs_ff;

   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> (i_ff < 5'(Steps))) else $error("cordic step overrun");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(run_ff && done_ff)) else $error("run and done both set");
   a_push: assert property (@(posedge clock) disable iff (reset)
      q_push |=> !done_ff) else $error("done held after push");
endmodule

@@ rtl/rps_matrix.sv @@
// Back part: builds T and E, computes rows of T*E*T^T, one multiply a cycle.
`timescale 1ns / 1ps
module rps_matrix #(
   parameter int FRAC_BITS = rps_pkg::FracBitsDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   output logic                        q_pop,
   input  logic signed [FRAC_BITS+1:0] q_sin,
   input  logic signed [FRAC_BITS+1:0] q_cos,
   input  rps_pkg::coefs_type          q_coefs,
   output logic                        rsp_valid,
   output logic [2:0]                  rsp_row,
   output logic signed [39:0]          rsp_col0,
   output logic signed [39:0]          rsp_col1,
   output logic signed [39:0]          rsp_col2,
   output logic signed [39:0]          rsp_col3,
   output logic signed [39:0]          rsp_col4,
   output logic signed [39:0]          rsp_col5,
   output logic                        rsp_last
);
   // Sequencer phases
   localparam logic [1:0] PhIdle = 2'd0;
   localparam logic [1:0] PhTrig = 2'd1;
   localparam logic [1:0] PhC    = 2'd2;
   localparam logic [1:0] PhR    = 2'd3;
   localparam int AW = 72;  // accumulator width
   localparam logic signed [AW-1:0] OutMax = AW'(40'sh7FFFFFFFFF);
   localparam logic signed [AW-1:0] OutMin = AW'(40'sh8000000000);

   logic [1:0] ph_ff, ph_in;
   logic [2:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [1:0] t_ff, t_in;
   logic signed [FRAC_BITS+1:0] s_ff, c_ff;
   logic signed [FRAC_BITS+2:0] cc_ff, ss_ff, cs_ff;
   rps_pkg::coefs_type          e_ff;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [39:0]  cm_ff [6];
   logic signed [39:0]  row_ff [6];
   logic signed [AW-1:0] prod;
   logic signed [FRAC_BITS+2:0] ma;
   logic signed [39:0]  mb;
   logic signed [AW-1:0] rnd;
   logic signed [AW-1:0] cl;
   logic                 fin;
   logic signed [39:0]  tl, el;
   logic [2:0]          ta, tb, ea, eb;
   logic                out_v_ff;
   logic [2:0]          out_row_ff;
   logic signed [39:0]  out_col_ff [6];

   function automatic logic signed [39:0] tget(input logic [2:0] r, input logic [2:0] c,
      input logic signed [FRAC_BITS+2:0] cc, input logic signed [FRAC_BITS+2:0] ss,
      input logic signed [FRAC_BITS+2:0] cs, input logic signed [FRAC_BITS+1:0] sv,
      input logic signed [FRAC_BITS+1:0] cv);
      logic signed [39:0] v;
      begin
         v = 40'sd0;
         case ({r, c})
            {3'd0, 3'd0}, {3'd2, 3'd2}: v = 40'(cc);
            {3'd1, 3'd1}: v = 40'sd1 <<< FRAC_BITS;
            {3'd3, 3'd3}, {3'd5, 3'd5}: v = 40'(cv);
            {3'd0, 3'd2}, {3'd2, 3'd0}: v = 40'(ss);
            {3'd4, 3'd0}: v = 40'(cs);
            {3'd4, 3'd2}: v = -40'(cs);
            {3'd0, 3'd4}: v = -(40'(cs) <<< 1);
            {3'd2, 3'd4}: v = 40'(cs) <<< 1;
            {3'd4, 3'd4}: v = 40'(cc) - 40'(ss);
            {3'd3, 3'd5}: v = -40'(sv);
            {3'd5, 3'd3}: v = 40'(sv);
            default: v = 40'sd0;
         endcase
         return v;
      end
   endfunction

   function automatic logic signed [39:0] eget(input logic [2:0] r, input logic [2:0] c,
      input rps_pkg::coefs_type e);
      logic signed [39:0] v;
      begin
         v = 40'sd0;
         case ({r, c})
            {3'd0, 3'd0}: v = 40'(e.d00) <<< 1;
            {3'd1, 3'd1}: v = 40'(e.d11) <<< 1;
            {3'd2, 3'd2}: v = 40'(e.d22) <<< 1;
            {3'd3, 3'd3}, {3'd4, 3'd4}: v = 40'(e.d33) <<< 1;
            {3'd0, 3'd1}, {3'd1, 3'd0}: v = 40'(e.o01) <<< 1;
            {3'd1, 3'd2}, {3'd2, 3'd1}: v = 40'(e.o12) <<< 1;
            {3'd2, 3'd3}, {3'd3, 3'd2}: v = 40'(e.o23) <<< 1;
            {3'd0, 3'd2}, {3'd2, 3'd0}: v = 40'(e.o02) <<< 1;
            {3'd1, 3'd3}, {3'd3, 3'd1}: v = 40'(e.o13) <<< 1;
            {3'd0, 3'd3}, {3'd3, 3'd0}: v = 40'(e.o03) <<< 1;
            {3'd5, 3'd5}: v = 40'(e.d11) - 40'(e.o12);
            default: v = 40'sd0;
         endcase
         return v;
      end
   endfunction

   // operand select: trig products, row i of C = T*E, then row i of C*T^T.
   // ma always carries the narrow trig/T side, mb the wide side.
   always_comb begin
      ta = 3'd0; tb = 3'd0; ea = 3'd0; eb = 3'd0;
      ma = '0; mb = 40'sd0;
      tl = 40'sd0; el = 40'sd0;
      case (ph_ff)
         PhTrig: begin
            case (t_ff)
               2'd0: begin ma = (FRAC_BITS+3)'(c_ff); mb = 40'(c_ff); end
               2'd1: begin ma = (FRAC_BITS+3)'(s_ff); mb = 40'(s_ff); end
               default: begin ma = (FRAC_BITS+3)'(c_ff); mb = 40'(s_ff); end
            endcase
         end
         PhC: begin
            ta = i_ff; tb = k_ff; ea = k_ff; eb = j_ff;
            tl = tget(ta, tb, cc_ff, ss_ff, cs_ff, s_ff, c_ff);
            el = eget(ea, eb, e_ff);
            ma = (FRAC_BITS+3)'(tl); mb = el;
         end
         PhR: begin
            tl = tget(j_ff, k_ff, cc_ff, ss_ff, cs_ff, s_ff, c_ff);
            ma = (FRAC_BITS+3)'(tl);
            mb = cm_ff[k_ff];
         end
         default: begin ma = '0; mb = 40'sd0; end
      endcase
   end

   assign prod = AW'(ma) * AW'(mb);

   always_comb begin
      ph_in = ph_ff; i_in = i_ff; j_in = j_ff; k_in = k_ff; t_in = t_ff;
      acc_in = acc_ff; fin = 1'b0; rnd = '0; cl = '0;
      q_pop = 1'b0;
      case (ph_ff)
         PhIdle: begin
            if (q_valid) begin
               q_pop = 1'b1; ph_in = PhTrig; t_in = 2'd0;
            end
         end
         PhTrig: begin
            t_in = t_ff + 2'd1;
            if (t_ff == 2'd2) begin
               ph_in = PhC; i_in = 3'd0; j_in = 3'd0; k_in = 3'd0; acc_in = '0;
            end
         end
         PhC: begin
            acc_in = acc_ff + prod;
            k_in = k_ff + 3'd1;
            if (k_ff == 3'd5) begin
               fin = 1'b1; k_in = 3'd0; acc_in = '0;
               rnd = (acc_ff + prod + (AW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
               j_in = j_ff + 3'd1;
               if (j_ff == 3'd5) begin
                  j_in = 3'd0; ph_in = PhR;
               end
            end
         end
         PhR: begin
            acc_in = acc_ff + prod;
            k_in = k_ff + 3'd1;
            if (k_ff == 3'd5) begin
               fin = 1'b1; k_in = 3'd0; acc_in = '0;
               rnd = (acc_ff + prod + (AW'(1) <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
               cl = rnd;
               if (rnd > OutMax) cl = OutMax;
               if (rnd < OutMin) cl = OutMin;
               j_in = j_ff + 3'd1;
               if (j_ff == 3'd5) begin
                  j_in = 3'd0; i_in = i_ff + 3'd1;
                  if (i_ff == 3'd5) ph_in = PhIdle;
                  else ph_in = PhC;
               end
            end
         end
         default: ph_in = PhIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PhIdle; out_v_ff <= 1'b0;
         i_ff <= 3'd0; j_ff <= 3'd0; k_ff <= 3'd0; t_ff <= 2'd0;
      end else begin
         ph_ff <= ph_in;
         out_v_ff <= (ph_ff == PhR) && fin && (j_ff == 3'd5);
         i_ff <= i_in; j_ff <= j_in; k_ff <= k_in; t_ff <= t_in;
      end
      acc_ff <= acc_in;
      if (q_pop) begin
         s_ff <= q_sin; c_ff <= q_cos; e_ff <= q_coefs;
      end
      if (ph_ff == PhTrig) begin
         case (t_ff)
            2'd0: cc_ff <= (FRAC_BITS+3)'((prod + (AW'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS);
            2'd1: ss_ff <= (FRAC_BITS+3)'((prod + (AW'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS);
            default: cs_ff <= (FRAC_BITS+3)'((prod + (AW'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS);
         endcase
      end
      if (ph_ff == PhC && fin) cm_ff[j_ff] <= 40'(rnd);
      if (ph_ff == PhR && fin) begin
         row_ff[j_ff] <= 40'(cl);
         if (j_ff == 3'd5) begin
            out_row_ff <= i_ff;
            for (int n = 0; n < 5; n++) out_col_ff[n] <= row_ff[n];
            out_col_ff[5] <= 40'(cl);
         end
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_row   = out_row_ff;
   assign rsp_col0  = out_col_ff[0];
   assign rsp_col1  = out_col_ff[1];
   assign rsp_col2  = out_col_ff[2];
   assign rsp_col3  = out_col_ff[3];
   assign rsp_col4  = out_col_ff[4];
   assign rsp_col5  = out_col_ff[5];
   assign rsp_last  = out_row_ff == rps_pkg::RowLast;

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (ph_ff == PhIdle)) else $error("pop outside idle");
   a_row_rng: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_row <= rps_pkg::RowLast)) else $error("row out of range");
   a_k_rng: assert property (@(posedge clock) disable iff (reset)
      (k_ff <= 3'd5)) else $error("k out of range");
endmodule

@@ rtl/rps_queue.sv @@
// Two-entry queue between the CORDIC front and the matrix back.
`timescale 1ns / 1ps
module rps_queue #(
   parameter int FRAC_BITS = rps_pkg::FracBitsDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic signed [FRAC_BITS+1:0] in_sin,
   input  logic signed [FRAC_BITS+1:0] in_cos,
   input  rps_pkg::coefs_type          in_coefs,
   output logic                        full,
   output logic                        valid,
   input  logic                        pop,
   output logic signed [FRAC_BITS+1:0] out_sin,
   output logic signed [FRAC_BITS+1:0] out_cos,
   output rps_pkg::coefs_type          out_coefs
);
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, rp_ff;
   logic signed [FRAC_BITS+1:0] s_ff [2], c_ff [2];
   rps_pkg::coefs_type          e_ff [2];

   assign full  = cnt_ff == 2'd2;
   assign valid = cnt_ff != 2'd0;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0; wp_ff <= 1'b0; rp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
      end
      if (push) begin
         s_ff[wp_ff] <= in_sin; c_ff[wp_ff] <= in_cos; e_ff[wp_ff] <= in_coefs;
      end
   end

   assign out_sin   = s_ff[rp_ff];
   assign out_cos   = c_ff[rp_ff];
   assign out_coefs = e_ff[rp_ff];

   a_no_ovf: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("queue overflow");
   a_no_udf: assert property (@(posedge clock) disable iff (reset)
      !(pop && !valid)) else $error("queue underflow");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2) else $error("queue count");
endmodule

@@ rtl/rotate_ply_stiffness_6x6.sv @@
// Top level: rotates a ply stiffness matrix, six result rows per item.
//
//  channel  | handshake          | payload
//  request  | start / busy       | req_angle, req_c_d00 .. req_c_o03
//  response | rsp_valid strobe   | rsp_row, rsp_col0 .. rsp_col5, rsp_last
//
// The front runs the CORDIC iterations for each item, then holds the result until
// the queue has room; it stays busy and takes no new transfer until it is pushed.
// The back has one multiplier: it pops an item while idle, forms the three trig
// products, then for each row computes that row of T*E and then of C*T^T; it pops
// no new item until all six rows are done, so the back sets the sustained rate.
// Synchronous active-high reset clears control; results cannot be stalled.
`timescale 1ns / 1ps
module rotate_ply_stiffness_6x6 #(
   parameter int FRAC_BITS    = rps_pkg::FracBitsDefault,
   parameter int CORDIC_STEPS = rps_pkg::CordicStepsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_angle,
   input  logic signed [31:0] req_c_d00,
   input  logic signed [31:0] req_c_d11,
   input  logic signed [31:0] req_c_d22,
   input  logic signed [31:0] req_c_d33,
   input  logic signed [31:0] req_c_o01,
   input  logic signed [31:0] req_c_o12,
   input  logic signed [31:0] req_c_o23,
   input  logic signed [31:0] req_c_o02,
   input  logic signed [31:0] req_c_o13,
   input  logic signed [31:0] req_c_o03,
   output logic               rsp_valid,
   output logic [2:0]         rsp_row,
   output logic signed [39:0] rsp_col0,
   output logic signed [39:0] rsp_col1,
   output logic signed [39:0] rsp_col2,
   output logic signed [39:0] rsp_col3,
   output logic signed [39:0] rsp_col4,
   output logic signed [39:0] rsp_col5,
   output logic               rsp_last
);
   rps_pkg::coefs_type          coefs, qc_in, qc_out;
   logic                        push, full, qv, pop;
   logic signed [FRAC_BITS+1:0] s_a, c_a, s_b, c_b;

   assign coefs = '{d00: req_c_d00, d11: req_c_d11, d22: req_c_d22, d33: req_c_d33,
                    o01: req_c_o01, o12: req_c_o12, o23: req_c_o23,
                    o02: req_c_o02, o13: req_c_o13, o03: req_c_o03};

   rps_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_front (
      .clock, .reset, .start, .busy, .req_angle, .req_coefs(coefs),
      .q_full(full), .q_push(push), .q_sin(s_a), .q_cos(c_a), .q_coefs(qc_in));

   rps_queue #(.FRAC_BITS(FRAC_BITS)) u_queue (
      .clock, .reset, .push, .in_sin(s_a), .in_cos(c_a), .in_coefs(qc_in),
      .full, .valid(qv), .pop, .out_sin(s_b), .out_cos(c_b), .out_coefs(qc_out));

   rps_matrix #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset, .q_valid(qv), .q_pop(pop), .q_sin(s_b), .q_cos(c_b),
      .q_coefs(qc_out), .rsp_valid, .rsp_row, .rsp_col0, .rsp_col1, .rsp_col2,
      .rsp_col3, .rsp_col4, .rsp_col5, .rsp_last);
endmodule

@@ tb/tb_rotate_ply_stiffness_6x6.sv @@
// Testbench for the ply stiffness rotation block: predicted rows checked per transfer.
`timescale 1ns / 1ps
module tb_rotate_ply_stiffness_6x6;

   localparam int FB = 16;
   localparam int STEPS = 16;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      logic signed [15:0] angle;
      logic signed [31:0] c [10];
   } ply_item_type;

   typedef struct {
      logic [2:0]         row;
      logic signed [39:0] col [6];
      logic               last;
   } row_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] req_angle = '0;
   logic signed [31:0] req_c [10];
   logic rsp_valid, rsp_last;
   logic [2:0] rsp_row;
   logic signed [39:0] rsp_col [6];

   ply_item_type   pending_items [$];
   row_result_type expected_rows [$];
   int  fail_count = 0;
   int  cycle_count = 0;
   int  burst_left = 0;
   int  gap_left = 0;

   initial for (int i = 0; i < 10; i++) req_c[i] = '0;

   rotate_ply_stiffness_6x6 DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_angle(req_angle),
      .req_c_d00(req_c[0]), .req_c_d11(req_c[1]), .req_c_d22(req_c[2]),
      .req_c_d33(req_c[3]), .req_c_o01(req_c[4]), .req_c_o12(req_c[5]),
      .req_c_o23(req_c[6]), .req_c_o02(req_c[7]), .req_c_o13(req_c[8]),
      .req_c_o03(req_c[9]),
      .rsp_valid(rsp_valid), .rsp_row(rsp_row),
      .rsp_col0(rsp_col[0]), .rsp_col1(rsp_col[1]), .rsp_col2(rsp_col[2]),
      .rsp_col3(rsp_col[3]), .rsp_col4(rsp_col[4]), .rsp_col5(rsp_col[5]),
      .rsp_last(rsp_last)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic longint shr_floor(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint shr_round(longint v, int n);
      if (n == 0) return v;
      return (v + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   // CORDIC in rotation mode, quadrant folded into the right half-plane
   function automatic void ply_sincos(logic signed [15:0] ang, output longint s,
                                      output longint c);
      logic [31:0] z;
      logic        flip;
      longint x, y, nx, zs;
      z = {ang, 16'h0};
      flip = (z[31:30] == 2'd1) || (z[31:30] == 2'd2);
      if (flip) z[31] = ~z[31];
      zs = longint'(signed'(z));
      x = 652032874;
      y = 0;
      for (int i = 0; i < STEPS; i++) begin
         if (zs >= 0) begin
            nx = x - shr_floor(y, i);
            y = y + shr_floor(x, i);
            zs -= longint'(rps_pkg::atan_val(i[4:0]));
         end else begin
            nx = x + shr_floor(y, i);
            y = y - shr_floor(x, i);
            zs += longint'(rps_pkg::atan_val(i[4:0]));
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = shr_round(x, 30 - FB);
      s = shr_round(y, 30 - FB);
   endfunction

   task automatic predict_rotated_rows(ply_item_type it);
      longint t [6][6], e [6][6], cm [6][6];
      longint s, c, cc, ss, cs, acc;
      longint d [10];
      row_result_type r;
      ply_sincos(it.angle, s, c);
      for (int i = 0; i < 10; i++) d[i] = longint'(it.c[i]);
      cc = shr_round(c * c, FB);
      ss = shr_round(s * s, FB);
      cs = shr_round(c * s, FB);
      for (int i = 0; i < 6; i++)
         for (int j = 0; j < 6; j++) begin
            t[i][j] = 0;
            e[i][j] = 0;
         end
      t[0][0] = cc; t[2][2] = cc; t[1][1] = 64'sd1 <<< FB;
      t[3][3] = c; t[5][5] = c; t[0][2] = ss; t[2][0] = ss;
      t[4][0] = cs; t[4][2] = -cs; t[0][4] = -2 * cs; t[2][4] = 2 * cs;
      t[4][4] = cc - ss; t[3][5] = -s; t[5][3] = s;
      for (int i = 0; i < 4; i++) e[i][i] = 2 * d[i];
      e[0][1] = 2 * d[4]; e[1][0] = e[0][1];
      e[1][2] = 2 * d[5]; e[2][1] = e[1][2];
      e[2][3] = 2 * d[6]; e[3][2] = e[2][3];
      e[0][2] = 2 * d[7]; e[2][0] = e[0][2];
      e[1][3] = 2 * d[8]; e[3][1] = e[1][3];
      e[0][3] = 2 * d[9]; e[3][0] = e[0][3];
      e[4][4] = 2 * d[3];
      e[5][5] = d[1] - d[5];
      for (int i = 0; i < 6; i++)
         for (int j = 0; j < 6; j++) begin
            acc = 0;
            for (int k = 0; k < 6; k++) acc += t[i][k] * e[k][j];
            cm[i][j] = shr_round(acc, FB);
         end
      for (int i = 0; i < 6; i++) begin
         r.row = i[2:0];
         r.last = (i == 5);
         for (int j = 0; j < 6; j++) begin
            acc = 0;
            for (int k = 0; k < 6; k++) acc += cm[i][k] * t[j][k];
            acc = shr_round(acc, FB + 1);
            if (acc > 64'sd549755813887) acc = 64'sd549755813887;
            if (acc < -64'sd549755813888) acc = -64'sd549755813888;
            r.col[j] = acc[39:0];
         end
         expected_rows.push_back(r);
      end
   endtask

   function automatic logic signed [31:0] pick_coef();
      case ($urandom_range(0, 5))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return 32'(signed'($urandom_range(0, 32'h00FFFFFF)));
         3: return -32'(signed'($urandom_range(0, 32'h00FFFFFF)));
         default: return $urandom;
      endcase
   endfunction

   // driver: bursts of back-to-back transfers with random gaps
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start && pending_items.size() > 0) void'(pending_items.pop_front());
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (pending_items.size() > 0) begin
            start <= 1'b1;
            req_angle <= pending_items[0].angle;
            for (int i = 0; i < 10; i++) req_c[i] <= pending_items[0].c[i];
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 8);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // prediction happens when the transfer is taken
   always @(posedge clock) begin
      ply_item_type taken;
      if (!reset && start && !busy) begin
         taken.angle = req_angle;
         for (int i = 0; i < 10; i++) taken.c[i] = req_c[i];
         predict_rotated_rows(taken);
      end
   end

   // monitor
   always @(posedge clock) begin
      row_result_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (expected_rows.size() == 0) begin
            $error("unexpected row transfer, row %0d", rsp_row);
            fail_count = fail_count + 1;
         end else begin
            want = expected_rows.pop_front();
            if (rsp_row !== want.row) begin
               $error("row: expected %0d actual %0d", want.row, rsp_row);
               fail_count = fail_count + 1;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d actual %0d", want.last, rsp_last);
               fail_count = fail_count + 1;
            end
            for (int j = 0; j < 6; j++)
               if (rsp_col[j] !== want.col[j]) begin
                  $error("col%0d: expected %0d actual %0d", j, want.col[j], rsp_col[j]);
                  fail_count = fail_count + 1;
               end
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      ply_item_type it;
      logic signed [15:0] angles [12];
      angles = '{16'sh0000, 16'sh4000, -16'sh4000, 16'sh7FFF, -16'sh8000, 16'sh2000,
                 16'sh3FFF, 16'sh4001, 16'shC000, 16'shBFFF, 16'sh0001, 16'shFFFF};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // directed: quadrant boundaries and coefficient extremes
      foreach (angles[a]) begin
         it.angle = angles[a];
         for (int i = 0; i < 10; i++) it.c[i] = (a % 3 == 0) ? 32'sh7FFFFFFF :
            (a % 3 == 1) ? 32'sh80000000 : 32'(signed'((i + 1) << 16));
         pending_items.push_back(it);
      end
      it.angle = 16'sh1555;
      for (int i = 0; i < 10; i++) it.c[i] = 32'sh0;
      pending_items.push_back(it);
      for (int i = 0; i < 10; i++) it.c[i] = (i % 2) ? 32'sh7FFFFFFF : 32'sh80000000;
      pending_items.push_back(it);
      for (int i = 0; i < 10; i++) it.c[i] = -32'sd1;
      pending_items.push_back(it);
      // random items
      repeat (245) begin
         it.angle = $urandom;
         for (int i = 0; i < 10; i++) it.c[i] = pick_coef();
         pending_items.push_back(it);
      end
      while (pending_items.size() != 0 || start) @(posedge clock);
      while (expected_rows.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && expected_rows.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/rps_pkg.sv
rtl/rps_cordic.sv
rtl/rps_matrix.sv
rtl/rps_queue.sv
rtl/rotate_ply_stiffness_6x6.sv
tb/tb_rotate_ply_stiffness_6x6.sv
